/* src/xrng_pkg.sv */
// Package: commands, constants and state types for the xoshiro256** unit.
`default_nettype none
package xrng_pkg;
    localparam int CmdWidth = 2;
    localparam int BoundWidth = 32;
    localparam int WordWidth = 64;

    typedef enum logic [CmdWidth-1:0] {
        CMD_RESEED  = 2'd0,
        CMD_RAW     = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_UNIT    = 2'd3
    } cmd_t;

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MIX1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MIX2  = 64'h94D049BB133111EB;

    // splitmix64 outputs for a seed of zero
    localparam logic [63:0] RESET_W0 = 64'hE220A8397B1DCDAF;
    localparam logic [63:0] RESET_W1 = 64'h6E789E6AA1B965F4;
    localparam logic [63:0] RESET_W2 = 64'h06C45D188009454F;
    localparam logic [63:0] RESET_W3 = 64'hF88BB8A8724C81EC;

    typedef logic [63:0] word_t;
endpackage
`default_nettype wire

/* src/xoshiro256ss_bounded_rng_unit.sv */
// Top level: xoshiro256** generator with reseed, raw, bounded and unit-fraction draws.
//
// Usage: one transaction on the s_ channel (s_cmd, s_bound) yields exactly one
// transaction on the m_ channel (m_value). cfg_we writes the 64-bit seed used by
// reseed commands; write it only while no command is in flight.
// A single shared 32x32 multiplier does the splitmix64 mixing products, cut into 32-bit
// partial products, and the bounded scaling, under a small sequencer; the scrambler's
// x5 and x9 use shifts and adds. A bit-serial divider forms the rejection threshold.
// Steps after acceptance: raw and unit draws pass DRAW and SCALE to OUT; a zero-bound
// draw goes straight to OUT; a bounded draw adds BMUL and BCHK, plus a one-time threshold
// division when needed and a new draw per rejected value; a reseed runs the splitmix64
// steps for each of the four state words, then goes to OUT.
// s_ready is high only while the sequencer is idle; one command is in work at a time.
// When the receiver stalls, the result is held in m_value with m_valid high; the next
// command still runs and holds in its last step until the output register is free.
// Reset (aresetn low, synchronous) loads the state for seed zero, clears the seed
// register and empties the output.
`default_nettype none
module xoshiro256ss_bounded_rng_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [31:0] s_bound,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_value
);
    import xrng_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_DRAW  = 13'b0000000000010,
        ST_SCALE = 13'b0000000000100,
        ST_BMUL  = 13'b0000000001000,
        ST_BCHK  = 13'b0000000010000,
        ST_DIV   = 13'b0000000100000,
        ST_SM    = 13'b0000001000000,
        ST_XS    = 13'b0000010000000,
        ST_ML    = 13'b0000100000000,
        ST_MH    = 13'b0001000000000,
        ST_MC    = 13'b0010000000000,
        ST_SMFIN = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t      state_reg, state_next;
    word_t       seed_reg;
    word_t       w_reg [4];
    cmd_t        cmd_reg;
    logic [31:0] bound_reg;
    logic [31:0] limit_reg;
    logic        lim_ok_reg;
    word_t       acc_reg;
    word_t       x_reg;
    word_t       prod_reg;
    word_t       res_reg;
    word_t       m_value_reg;
    logic        m_valid_reg;
    logic        phase_reg;
    logic [1:0]  idx_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;

    logic accept;
    logic out_load;
    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    word_t w1x5, rot7, star, acc_sum, zmix, mconst, w2_mix, w3_mix;
    assign w1x5    = {w_reg[1][61:0], 2'b00} + w_reg[1];
    assign rot7    = {w1x5[56:0], w1x5[63:57]};
    assign star    = {x_reg[60:0], 3'b000} + x_reg;
    assign acc_sum = acc_reg + SM_GAMMA;
    assign zmix    = phase_reg ? (x_reg ^ (x_reg >> 27)) : (x_reg ^ (x_reg >> 30));
    assign mconst  = phase_reg ? SM_MIX2 : SM_MIX1;
    assign w2_mix  = w_reg[2] ^ w_reg[0];
    assign w3_mix  = w_reg[3] ^ w_reg[1];

    logic [32:0] rem_sh, rem_dif;
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_dif = rem_sh - {1'b0, bound_reg};

    // operand select: 64x64 low product as a_lo*b_lo + (a_hi*b_lo + a_lo*b_hi)<<32
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_ML: begin
                mul_a = x_reg[31:0];
                mul_b = mconst[31:0];
            end
            ST_MH: begin
                mul_a = x_reg[63:32];
                mul_b = mconst[31:0];
            end
            ST_MC: begin
                mul_a = x_reg[31:0];
                mul_b = mconst[63:32];
            end
            ST_BMUL: begin
                mul_a = x_reg[63:32];
                mul_b = bound_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_RESEED) state_next = ST_SM;
                    else if (s_cmd == CMD_BOUNDED && s_bound == 32'd0) state_next = ST_OUT;
                    else state_next = ST_DRAW;
                end
            end
            ST_DRAW:  state_next = ST_SCALE;
            ST_SCALE: state_next = (cmd_reg == CMD_BOUNDED) ? ST_BMUL : ST_OUT;
            ST_BMUL:  state_next = ST_BCHK;
            ST_BCHK: begin
                if (prod_reg[31:0] >= bound_reg) state_next = ST_OUT;
                else if (!lim_ok_reg) state_next = ST_DIV;
                else if (prod_reg[31:0] < limit_reg) state_next = ST_DRAW;
                else state_next = ST_OUT;
            end
            ST_DIV:   if (cnt_reg == 6'd32) state_next = ST_BCHK;
            ST_SM:    state_next = ST_XS;
            ST_XS:    state_next = ST_ML;
            ST_ML:    state_next = ST_MH;
            ST_MH:    state_next = ST_MC;
            ST_MC:    state_next = phase_reg ? ST_SMFIN : ST_XS;
            ST_SMFIN: state_next = (idx_reg == 2'd3) ? ST_OUT : ST_SM;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= '0;
            w_reg[0]    <= RESET_W0;
            w_reg[1]    <= RESET_W1;
            w_reg[2]    <= RESET_W2;
            w_reg[3]    <= RESET_W3;
            cmd_reg     <= CMD_RESEED;
            bound_reg   <= '0;
            limit_reg   <= '0;
            lim_ok_reg  <= 1'b0;
            acc_reg     <= '0;
            x_reg       <= '0;
            prod_reg    <= '0;
            res_reg     <= '0;
            m_value_reg <= '0;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
            idx_reg     <= 2'd0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) seed_reg <= cfg_wdata;
            if (out_load) begin
                m_value_reg <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg    <= cmd_t'(s_cmd);
                        bound_reg  <= s_bound;
                        lim_ok_reg <= 1'b0;
                        acc_reg    <= seed_reg;
                        idx_reg    <= 2'd0;
                        phase_reg  <= 1'b0;
                        res_reg    <= '0;
                    end
                end
                ST_DRAW: begin
                    x_reg    <= rot7;
                    w_reg[0] <= w_reg[0] ^ w3_mix;
                    w_reg[1] <= w_reg[1] ^ w2_mix;
                    w_reg[2] <= w2_mix ^ {w_reg[1][46:0], 17'd0};
                    w_reg[3] <= {w3_mix[18:0], w3_mix[63:19]};
                end
                ST_SCALE: begin
                    if (cmd_reg == CMD_RAW) res_reg <= star;
                    else if (cmd_reg == CMD_UNIT) res_reg <= {11'd0, star[63:11]};
                    else x_reg <= star;
                end
                ST_BMUL: prod_reg <= mul_p;
                ST_BCHK: begin
                    if (prod_reg[31:0] >= bound_reg ||
                        (lim_ok_reg && prod_reg[31:0] >= limit_reg)) begin
                        res_reg <= {32'd0, prod_reg[63:32]};
                    end else if (!lim_ok_reg) begin
                        rem_reg <= '0;
                        dvd_reg <= 32'd0 - bound_reg;
                        cnt_reg <= '0;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == 6'd32) begin
                        limit_reg  <= rem_reg;
                        lim_ok_reg <= 1'b1;
                    end else begin
                        rem_reg <= (rem_sh >= {1'b0, bound_reg}) ? rem_dif[31:0] : rem_sh[31:0];
                        dvd_reg <= {dvd_reg[30:0], 1'b0};
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_SM: begin
                    acc_reg <= acc_sum;
                    x_reg   <= acc_sum;
                end
                ST_XS: x_reg <= zmix;
                ST_ML: prod_reg <= mul_p;
                ST_MH: prod_reg[63:32] <= prod_reg[63:32] + mul_p[31:0];
                ST_MC: begin
                    x_reg     <= {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};
                    phase_reg <= !phase_reg;
                end
                ST_SMFIN: begin
                    w_reg[idx_reg] <= x_reg ^ (x_reg >> 31);
                    idx_reg        <= idx_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value))) else $error("result lost");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid) else $error("no result");
    a_limit_below: assert property (@(posedge aclk) disable iff (!aresetn)
        lim_ok_reg |-> (limit_reg < bound_reg)) else $error("threshold out of range");
`endif
endmodule
`default_nettype wire
